@@ rtl/bdq_pkg.sv @@
// Shared opcodes, status codes and cell control type for the bounded deque.
package bdq_pkg;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
   localparam logic [2:0] OP_CLEAR      = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // a: front-aligned copy (cell 0 holds the front)
   // b: back-aligned copy  (cell 0 holds the back)
   typedef struct packed {
      logic a_shift_up;
      logic a_shift_down;
      logic a_write;
      logic b_shift_up;
      logic b_shift_down;
      logic b_write;
   } cell_ctrl_type;

endpackage

@@ rtl/bdq_cell.sv @@
// One deque cell: a word of the front-aligned copy and a word of the back-aligned copy.
module bdq_cell #(
   parameter int WORD_BITS = 32,
   parameter int COUNT_BITS = 5,
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  bdq_pkg::cell_ctrl_type        ctrl,
   input  logic [COUNT_BITS-1:0]         count,
   input  logic [WORD_BITS-1:0]          wdata,
   input  logic [WORD_BITS-1:0]          a_lower,
   input  logic [WORD_BITS-1:0]          a_upper,
   input  logic [WORD_BITS-1:0]          b_lower,
   input  logic [WORD_BITS-1:0]          b_upper,
   output logic [WORD_BITS-1:0]          a_word,
   output logic [WORD_BITS-1:0]          b_word
);

   localparam logic [COUNT_BITS-1:0] SLOT = COUNT_BITS'(INDEX);

   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic                 at_count;

   assign at_count = (count == SLOT);

   always_comb begin
      a_in = a_ff;
      if (ctrl.a_shift_up) begin
         a_in = a_lower;
      end else if (ctrl.a_shift_down) begin
         a_in = a_upper;
      end else if (ctrl.a_write && at_count) begin
         a_in = wdata;
      end
   end

   always_comb begin
      b_in = b_ff;
      if (ctrl.b_shift_up) begin
         b_in = b_lower;
      end else if (ctrl.b_shift_down) begin
         b_in = b_upper;
      end else if (ctrl.b_write && at_count) begin
         b_in = wdata;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign a_word = a_ff;
   assign b_word = b_ff;

endmodule

@@ rtl/bounded_deque.sv @@
// Bounded double-ended queue built as a row of shifting cells.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_opcode, req_push_value
//   rsp     | out       | rsp_valid/rsp_ready | rsp_read_value, rsp_status, rsp_entry_count
//
// One transaction per cycle when not stalled: every operation completes in the cycle it
// is taken, the cells shift or load in place and the result lands in the output register.
// req_ready is high whenever the output register is empty or being drained.
// Reset (synchronous) clears the count and the output valid; cell contents are kept.
// A stalled rsp holds its result and blocks further requests until taken.
module bounded_deque #(
   parameter int DEPTH = 16,
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_entry_count
);

   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);
   localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

   logic [COUNT_BITS-1:0]  count_ff, count_in, count_next;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]     rsp_read_value_ff;
   logic [1:0]             rsp_status_ff, status_next;
   logic [4:0]             rsp_entry_count_ff;
   logic [31:0]            count_wide;

   logic                   fire;
   logic                   full;
   logic                   empty;
   logic [WORD_BITS-1:0]   push_word;
   logic [WORD_BITS-1:0]   read_word;
   logic [31:0]            read_out;
   bdq_pkg::cell_ctrl_type ctrl_next, ctrl;

   logic [WORD_BITS-1:0]   a_word [DEPTH];
   logic [WORD_BITS-1:0]   b_word [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);
   assign push_word = WORD_BITS'($unsigned(req_push_value));

   always_comb begin
      ctrl_next  = '0;
      read_word  = '0;
      status_next = bdq_pkg::ST_OK;
      count_next = count_ff;
      unique case (req_opcode)
         bdq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status_next = bdq_pkg::ST_FULL;
            end else begin
               ctrl_next.a_shift_up = 1'b1;
               ctrl_next.b_write    = 1'b1;
               count_next           = count_ff + ONE;
            end
         end
         bdq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status_next = bdq_pkg::ST_FULL;
            end else begin
               ctrl_next.b_shift_up = 1'b1;
               ctrl_next.a_write    = 1'b1;
               count_next           = count_ff + ONE;
            end
         end
         bdq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status_next = bdq_pkg::ST_EMPTY;
            end else begin
               read_word              = a_word[0];
               ctrl_next.a_shift_down = 1'b1;
               count_next             = count_ff - ONE;
            end
         end
         bdq_pkg::OP_POP_BACK: begin
            if (empty) begin
               status_next = bdq_pkg::ST_EMPTY;
            end else begin
               read_word              = b_word[0];
               ctrl_next.b_shift_down = 1'b1;
               count_next             = count_ff - ONE;
            end
         end
         bdq_pkg::OP_PEEK_FRONT: begin
            if (empty) begin
               status_next = bdq_pkg::ST_EMPTY;
            end else begin
               read_word = a_word[0];
            end
         end
         bdq_pkg::OP_PEEK_BACK: begin
            if (empty) begin
               status_next = bdq_pkg::ST_EMPTY;
            end else begin
               read_word = b_word[0];
            end
         end
         bdq_pkg::OP_CLEAR: begin
            count_next = '0;
         end
         default: begin
         end
      endcase
   end

   assign ctrl = fire ? ctrl_next : '0;

   generate
      if (WORD_BITS < 32) begin : g_sext
         assign read_out = {{(32 - WORD_BITS){read_word[WORD_BITS-1]}}, read_word};
      end else begin : g_trunc
         assign read_out = read_word[31:0];
      end
   endgenerate

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [WORD_BITS-1:0] a_lower, a_upper, b_lower, b_upper;
         if (gi == 0) begin : g_first
            assign a_lower = push_word;
            assign b_lower = push_word;
         end else begin : g_mid
            assign a_lower = a_word[gi-1];
            assign b_lower = b_word[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign a_upper = a_word[gi];
            assign b_upper = b_word[gi];
         end else begin : g_inner
            assign a_upper = a_word[gi+1];
            assign b_upper = b_word[gi+1];
         end
         bdq_cell #(
            .WORD_BITS (WORD_BITS),
            .COUNT_BITS(COUNT_BITS),
            .INDEX     (gi)
         ) u_cell (
            .clock  (clock),
            .ctrl   (ctrl),
            .count  (count_ff),
            .wdata  (push_word),
            .a_lower(a_lower),
            .a_upper(a_upper),
            .b_lower(b_lower),
            .b_upper(b_upper),
            .a_word (a_word[gi]),
            .b_word (b_word[gi])
         );
      end
   endgenerate

   assign count_in     = fire ? count_next : count_ff;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   assign count_wide   = 32'(count_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_read_value_ff  <= read_out;
         rsp_status_ff      <= status_next;
         rsp_entry_count_ff <= count_wide[4:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond depth");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      fire && full && (req_opcode == bdq_pkg::OP_PUSH_FRONT ||
                       req_opcode == bdq_pkg::OP_PUSH_BACK)
      |=> count_ff == $past(count_ff) && rsp_status == bdq_pkg::ST_FULL)
      else $error("push on full deque changed the count");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      fire && req_opcode == bdq_pkg::OP_CLEAR |=> count_ff == '0)
      else $error("clear left entries behind");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bdq_pkg::ST_EMPTY |-> rsp_read_value == '0)
      else $error("empty read returned data");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("transaction taken while result stalled");

endmodule
